### hw/rtl/zcsw_pkg.sv
// Shared types, codes and constants of the zero-crossing scan-window timer.
`default_nettype none

package zcsw_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [1:0]  EXT_RELOAD   = 2'd2;
  localparam logic [15:0] STARTUP_BIAS = 16'h4000;

  typedef enum logic {
    OP_BEGIN  = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_SCANNING  = 2'd0,
    ST_READY     = 2'd1,
    ST_TIMED_OUT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_WAIT   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_EXTEND = 2'd2
  } action_e;

  // Operation on top, then the tdata fields from the highest bit down.
  typedef struct packed {
    op_e         operation;
    logic        initial_run_mode;
    logic        startup_mode;
    logic [15:0] period_times_four;
    logic [31:0] run_timeout;
    logic [31:0] scan_wait;
    logic        cmp_hit;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [15:0] read_count;
    logic [31:0] timeout_length;
    action_e     tmr_action;
    status_e     status;
  } result_t;

  // Deadline reached when (t - due) is non-negative modulo 2^32.
  function automatic logic reached(logic [31:0] t, logic [31:0] due);
    logic [31:0] diff;
    diff = t - due;
    return ~diff[31];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/zcsw_in_stage.sv
// Input register: captures one word from the slave stream.
`default_nettype none

module zcsw_in_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [zcsw_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic [zcsw_pkg::IN_USER_W-1:0]       s_axis_tuser,
  input  logic                                 advance_i,
  output logic                                 valid_o,
  output zcsw_pkg::item_t                      item_o
);
  import zcsw_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  assign s_axis_tready = ~valid_q | advance_i;
  assign load          = s_axis_tvalid & s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_t'({s_axis_tuser[0], s_axis_tdata[$bits(item_t)-2:0]});
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### hw/rtl/zcsw_core.sv
// Window state and the single-pass begin/update logic.
`default_nettype none

module zcsw_core #(
  parameter int unsigned COUNT_WIDTH = zcsw_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              fast_clock_i,
  input  zcsw_pkg::item_t   item_i,
  output zcsw_pkg::result_t result_o
);
  import zcsw_pkg::*;

  logic [31:0]            scan_due_q, scan_due_d;
  logic [31:0]            timeout_due_q, timeout_due_d;
  logic [31:0]            armed_q, armed_d;
  logic [1:0]             ext_left_q, ext_left_d;
  logic [COUNT_WIDTH-1:0] reads_q, reads_d;
  logic                   begun_q, begun_d;
  logic                   expired_q, expired_d;
  logic                   startup_q, startup_d;
  action_e                action_q, action_d;

  logic [15:0] half;
  logic [31:0] len;
  logic [31:0] reads_ext;
  logic        go;
  status_e     status;

  // Timeout length armed by a begin word.
  always_comb begin
    half = item_i.period_times_four >> 1;
    if (!fast_clock_i) begin
      half = half >> 1;
    end
    if (item_i.startup_mode) begin
      half = half + STARTUP_BIAS;
    end
    len = (item_i.startup_mode | item_i.initial_run_mode) ? {16'b0, half}
                                                          : item_i.run_timeout;
  end

  always_comb begin
    scan_due_d    = scan_due_q;
    timeout_due_d = timeout_due_q;
    armed_d       = armed_q;
    ext_left_d    = ext_left_q;
    reads_d       = reads_q;
    begun_d       = begun_q;
    expired_d     = expired_q;
    startup_d     = startup_q;
    action_d      = action_q;
    status        = ST_SCANNING;
    go            = 1'b0;

    if (item_i.operation == OP_BEGIN) begin
      scan_due_d    = item_i.now + item_i.scan_wait;
      timeout_due_d = item_i.now + len;
      armed_d       = len;
      ext_left_d    = EXT_RELOAD;
      reads_d       = '0;
      begun_d       = 1'b0;
      expired_d     = 1'b0;
      startup_d     = item_i.startup_mode;
      action_d      = ACT_WAIT;
    end else if (expired_q) begin
      status = ST_TIMED_OUT;
    end else begin
      go = 1'b1;
      if (!begun_q) begin
        if (!reached(item_i.now, scan_due_q)) begin
          go = 1'b0;
        end else begin
          begun_d    = 1'b1;
          ext_left_d = EXT_RELOAD;
          action_d   = ACT_SET;
        end
      end
      if (go) begin
        reads_d = reads_q + COUNT_WIDTH'(1);
        if (item_i.cmp_hit) begin
          status = ST_READY;
        end else if (reached(item_i.now, timeout_due_q)) begin
          // Grant the single startup extension unless the counter just wrapped.
          if (startup_q && (reads_d != '0) && (ext_left_d > 2'd1)) begin
            ext_left_d    = ext_left_d - 2'd1;
            timeout_due_d = item_i.now + armed_q;
            action_d      = ACT_EXTEND;
          end else begin
            expired_d = 1'b1;
            status    = ST_TIMED_OUT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_due_q    <= '0;
      timeout_due_q <= '0;
      armed_q       <= '0;
      ext_left_q    <= EXT_RELOAD;
      reads_q       <= '0;
      begun_q       <= 1'b0;
      expired_q     <= 1'b0;
      startup_q     <= 1'b0;
      action_q      <= ACT_WAIT;
    end else if (advance_i) begin
      scan_due_q    <= scan_due_d;
      timeout_due_q <= timeout_due_d;
      armed_q       <= armed_d;
      ext_left_q    <= ext_left_d;
      reads_q       <= reads_d;
      begun_q       <= begun_d;
      expired_q     <= expired_d;
      startup_q     <= startup_d;
      action_q      <= action_d;
    end
  end

  assign reads_ext = 32'(reads_d);

  always_comb begin
    result_o.status         = status;
    result_o.tmr_action     = action_d;
    result_o.timeout_length = armed_d;
    result_o.read_count     = reads_ext[15:0];
  end

endmodule

`default_nettype wire

### hw/rtl/zcsw_out_stage.sv
// Result register toward the master stream.
`default_nettype none

module zcsw_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  zcsw_pkg::result_t               result_i,
  output logic                            can_load_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [zcsw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import zcsw_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  // Reload when empty or when the held word leaves this cycle.
  assign can_load_o = ~valid_q | m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), result_q};

endmodule

`default_nettype wire

### hw/rtl/zero_cross_scan_window_top.sv
// Zero-crossing scan-window timer: top level with configuration register.
//
// Slave stream s_axis carries begin and update words (tuser selects which);
// every accepted word yields exactly one result word on m_axis. A begin word
// arms the scan and timeout deadlines from its timestamp; update words check
// the timestamp against them with wrap-around, count comparator reads and
// report scanning, ready or timed out together with the timer action.
// The cfg channel writes fast_clock; it is always ready. The user must write
// it only while no word is in flight; the block itself does not enforce this.
// An accepted word waits in the input register; the window logic between the
// input and result registers works on it, and the result register loads the
// result once it is empty or its held word leaves. Throughput is one word per
// cycle while m_axis does not stall; the window state updates in the same
// cycle an item moves into the result register, so the next word sees it.
// When m_axis stalls, the result register holds its word and the input
// register still takes one more word, after which s_axis_tready drops.
// Reset empties both registers and returns the window state to idle with
// fast_clock cleared.
`default_nettype none

module zero_cross_scan_window_top #(
  parameter int unsigned COUNT_WIDTH = zcsw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [0:0]                      cfg_data_i,     // fast_clock
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now[31:0], cmp_hit[32], scan_wait[64:33], run_timeout[96:65],
  // period_times_four[112:97], startup_mode[113], initial_run_mode[114]
  input  logic [zcsw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  logic [zcsw_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], tmr_action[3:2], timeout_length[35:4], read_count[51:36]
  output logic [zcsw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import zcsw_pkg::*;

  logic    fast_clock_q;
  logic    in_valid;
  item_t   item;
  result_t result;
  logic    out_can_load;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_clock_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fast_clock_q <= cfg_data_i[0];
    end
  end

  assign advance = in_valid & out_can_load;

  zcsw_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  zcsw_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .fast_clock_i (fast_clock_q),
    .item_i       (item),
    .result_o     (result)
  );

  zcsw_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .result_i      (result),
    .can_load_o    (out_can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### hw/rtl/zcsw_checker.sv
// Port-level checks of the scan-window timer, bound to the top level.
`default_nettype none

module zcsw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [zcsw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import zcsw_pkg::*;

  logic [1:0]  status;
  logic [1:0]  action;
  logic [15:0] count;
  logic [15:0] len_hi;

  assign status = m_axis_tdata[1:0];
  assign action = m_axis_tdata[3:2];
  assign count  = m_axis_tdata[51:36];
  assign len_hi = m_axis_tdata[35:20];

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Before scanning starts no read is counted and nothing is found.
  a_wait_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && action == ACT_WAIT |-> count == 16'd0 && status == ST_SCANNING)
    else $error("activity reported while waiting for scan");

  // Extensions happen only in startup, where the armed timeout fits in 16 bits.
  a_extend_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && action == ACT_EXTEND |-> len_hi == 16'd0)
    else $error("extension reported with a run-mode timeout");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status != 2'd3 && action != 2'd3)
    else $error("undefined status or action code");

endmodule

bind zero_cross_scan_window_top zcsw_checker u_zcsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### sim/zero_cross_scan_window_top_test.sv
// Stream-level test of the zero-crossing scan-window timer against a cycle-free window predictor.
`default_nettype none

module zero_cross_scan_window_top_test;
  import zcsw_pkg::*;

  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [0:0]            cfg_data_i;       // fast_clock
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // now, cmp_hit, scan_wait, run_timeout, period_times_four,
  // startup_mode, initial_run_mode
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;     // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // status, tmr_action, timeout_length, read_count
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // window predictor state
  logic        fast_clock_q = 1'b0;
  logic [31:0] zc_scan_due = '0;
  logic [31:0] zc_timeout_due = '0;
  logic [31:0] zc_length = '0;
  logic [1:0]  zc_ext_left = EXT_RELOAD;
  logic [15:0] zc_reads = '0;
  logic        zc_scanning = 1'b0;
  logic        zc_expired = 1'b0;
  logic        zc_startup = 1'b0;
  action_e     zc_action = ACT_WAIT;

  result_t     pending_results[$];
  result_t     seen_word;
  result_t     want_word;
  logic [31:0] last_now = '0;
  int          words_sent = 0;
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          holdoff_asked = 0;
  int          holdoff_taken = 0;
  int          holdoff_left = 0;
  int          quiet_cycles = 0;

  zero_cross_scan_window_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic deadline_hit(logic [31:0] t, logic [31:0] due);
    logic [31:0] diff;
    diff = t - due;
    return !diff[31];
  endfunction

  // Advance the window state by one word and return the result it produces.
  function automatic result_t window_predict(item_t w);
    result_t     r;
    logic [15:0] half;
    logic [31:0] len;
    status_e     st;
    if (w.operation == OP_BEGIN) begin
      if (!w.startup_mode && !w.initial_run_mode) begin
        len = w.run_timeout;
      end else begin
        half = w.period_times_four >> 1;
        if (!fast_clock_q) half = half >> 1;
        if (w.startup_mode) half = half + STARTUP_BIAS;
        len = {16'd0, half};
      end
      zc_scan_due    = w.now + w.scan_wait;
      zc_timeout_due = w.now + len;
      zc_length      = len;
      zc_ext_left    = EXT_RELOAD;
      zc_reads       = '0;
      zc_scanning    = 1'b0;
      zc_expired     = 1'b0;
      zc_startup     = w.startup_mode;
      zc_action      = ACT_WAIT;
      st = ST_SCANNING;
    end else if (zc_expired) begin
      st = ST_TIMED_OUT;
    end else if (!zc_scanning && !deadline_hit(w.now, zc_scan_due)) begin
      st = ST_SCANNING;
    end else begin
      if (!zc_scanning) begin
        zc_scanning = 1'b1;
        zc_ext_left = EXT_RELOAD;
        zc_action   = ACT_SET;
      end
      zc_reads = zc_reads + 16'd1;
      if (w.cmp_hit) begin
        st = ST_READY;
      end else if (deadline_hit(w.now, zc_timeout_due)) begin
        // a wrapped read counter forfeits the extension
        if (zc_startup && zc_reads != 16'd0 && zc_ext_left > 2'd1) begin
          zc_ext_left    = zc_ext_left - 2'd1;
          zc_timeout_due = w.now + zc_length;
          zc_action      = ACT_EXTEND;
          st = ST_SCANNING;
        end else begin
          zc_expired = 1'b1;
          st = ST_TIMED_OUT;
        end
      end else begin
        st = ST_SCANNING;
      end
    end
    r.status         = st;
    r.tmr_action     = zc_action;
    r.timeout_length = zc_length;
    r.read_count     = zc_reads;
    return r;
  endfunction

  function automatic item_t word_of(op_e op, logic [31:0] now, logic q, logic [31:0] delay,
                                    logic [31:0] base, logic [15:0] p4, logic su, logic ir);
    item_t w;
    w.operation         = op;
    w.now               = now;
    w.cmp_hit           = q;
    w.scan_wait         = delay;
    w.run_timeout       = base;
    w.period_times_four = p4;
    w.startup_mode      = su;
    w.initial_run_mode  = ir;
    return w;
  endfunction

  // Fields an update ignores still get random content.
  function automatic item_t update_word(logic [31:0] now, logic q);
    return word_of(OP_UPDATE, now, q, $urandom(), $urandom(), 16'($urandom_range(16'hFFFF)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Offer one word; tvalid stays high after acceptance so a following word goes back to back.
  task automatic send_word(input item_t w);
    logic [IN_DATA_W-1:0] flat;
    flat = '0;
    flat[$bits(item_t)-2:0] = w[$bits(item_t)-2:0];
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= flat;
    s_axis_tuser  <= w.operation;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(window_predict(w));
    last_now = w.now;
    words_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_fast_clock(input logic v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    fast_clock_q = v;
    cfg_valid_i <= 1'b0;
  endtask

  // One begin word (unless skipped) and a run of updates whose time mostly advances, with an occasional random jump.
  task automatic run_window(input bit with_begin);
    logic [31:0] cur;
    logic [31:0] delay;
    logic [31:0] base;
    logic [31:0] span;
    logic [1:0]  mode;
    int          n;
    int          pick;
    cur = last_now;
    if (with_begin) begin
      cur   = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(300) : $urandom();
      mode  = 2'($urandom_range(3));
      delay = ($urandom_range(3) != 0) ? $urandom_range(40) : $urandom();
      base  = ($urandom_range(3) != 0) ? $urandom_range(150) : $urandom();
      send_word(word_of(OP_BEGIN, cur, 1'($urandom_range(1)), delay, base,
                        16'($urandom_range(16'hFFFF)), mode[0], mode[1]));
    end
    span = (zc_length >> 2) + ((zc_scan_due - cur) >> 2) + 32'd4;
    if (span > 32'h1000_0000) span = 32'h1000_0000;
    n = $urandom_range(40, 2);
    repeat (n) begin
      pick = $urandom_range(9);
      if (pick < 4) cur = cur + $urandom_range(6);
      else if (pick < 9) cur = cur + $urandom_range(span);
      else cur = $urandom();
      send_word(update_word(cur, $urandom_range(11) == 0));
    end
  endtask

  task automatic test_reset_state();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_word(update_word(32'h8000_0000, 1'b0));
    send_word(update_word(32'h0, 1'b0));
    send_word(update_word(32'hFFFF_FFFF, 1'b1));
  endtask

  task automatic test_directed_windows();
    // run mode, largest timeout, scan deadline wrapping past zero
    send_word(word_of(OP_BEGIN, 32'hFFFF_FFF0, 1'b1, 32'h20, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0));
    send_word(update_word(32'hFFFF_FFF8, 1'b1));
    send_word(update_word(32'h0000_0010, 1'b1));
    send_word(update_word(32'h0000_0020, 1'b0));
    // startup at slow clock: one extension, then time out and hold
    send_word(word_of(OP_BEGIN, 32'h1000, 1'b0, 32'h0, 32'h0, 16'hFFFF, 1'b1, 1'b0));
    send_word(update_word(32'h1000, 1'b0));
    send_word(update_word(32'h8FFF, 1'b0));
    send_word(update_word(32'h1_0FFE, 1'b0));
    send_word(update_word(32'h1_0FFF, 1'b1));
    // initial run never extends
    send_word(word_of(OP_BEGIN, 32'h8000_0000, 1'b1, 32'h5, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1));
    send_word(update_word(32'h8000_0004, 1'b0));
    send_word(update_word(32'h8000_3FFF, 1'b0));
    // both modes, zero period, scan deadline one tick behind now
    send_word(word_of(OP_BEGIN, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b1, 1'b1));
    send_word(update_word(32'h0, 1'b0));
    send_word(update_word(32'h4000, 1'b1));
    send_word(update_word(32'h4000, 1'b0));
    write_fast_clock(1'b1);
    send_word(word_of(OP_BEGIN, 32'h7, 1'b1, 32'h3, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0));
    send_word(update_word(32'h7 + 32'hBFFF, 1'b0));
    send_word(word_of(OP_BEGIN, 32'h0, 1'b0, 32'h0, 32'h0, 16'hFFFF, 1'b0, 1'b1));
    send_word(word_of(OP_BEGIN, 32'h55AA, 1'b0, 32'h0, 32'h0, 16'h1234, 1'b0, 1'b0));
    send_word(update_word(32'h55AA, 1'b0));
    write_fast_clock(1'b0);
  endtask

  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    holdoff_asked++;
    run_window(1'b1);
    run_window(1'b1);
    // pause the sender until every result is out, then resume mid-window
    wait_drained();
    run_window(1'b0);
    wait_drained();
  endtask

  task automatic test_random();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      write_fast_clock(ph[0]);
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      target = words_sent + 420;
      while (words_sent < target) run_window($urandom_range(9) != 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if (holdoff_taken != holdoff_asked) begin
      holdoff_taken++;
      holdoff_left = HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready) begin
      seen_word = m_axis_tdata[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        want_word = pending_results.pop_front();
        if (seen_word.status != want_word.status ||
            seen_word.tmr_action != want_word.tmr_action ||
            seen_word.timeout_length != want_word.timeout_length ||
            seen_word.read_count != want_word.read_count ||
            m_axis_tdata[OUT_DATA_W-1:$bits(result_t)] != '0) begin
          note_failure($sformatf(
            "mismatch: expected st=%0d act=%0d len=%h cnt=%0d, got st=%0d act=%0d len=%h cnt=%0d pad=%h",
            want_word.status, want_word.tmr_action, want_word.timeout_length,
            want_word.read_count, seen_word.status, seen_word.tmr_action,
            seen_word.timeout_length, seen_word.read_count,
            m_axis_tdata[OUT_DATA_W-1:$bits(result_t)]));
        end
      end
    end
  end

  // Stop a hung run: count cycles with no word moving on any channel.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("zero_cross_scan_window_top_test: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_windows();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("zero_cross_scan_window_top_test: clean");
    end else begin
      $display("zero_cross_scan_window_top_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
